// ----- src/fpv_pkg.sv -----
// Types, constants and helper functions for the first-person view matrix unit.
`timescale 1ns / 1ps
package fpv_pkg;

  localparam int MA_W  = 18;
  localparam int MB_W  = 34;
  localparam int ACC_W = 52;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [15:0] SENS_RESET   = 16'd256;
  localparam logic signed [ACC_W-1:0] PITCH_MAX = 52'sd16382;
  localparam logic signed [ACC_W-1:0] PITCH_MIN = -52'sd16382;
  localparam logic signed [MB_W-1:0]  POLY_A = 34'sd51472;
  localparam logic signed [MB_W-1:0]  POLY_B = 34'sd21024;
  localparam logic signed [MB_W-1:0]  POLY_C = 34'sd2320;
  localparam logic [16:0] QUAD_ONE = 17'd32768;

  typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_e;

  typedef enum logic [5:0] {
    SQ_DYAW, SQ_DPITCH,
    SQ_SY_SQ, SQ_SY_C, SQ_SY_B, SQ_SY_A,
    SQ_CY_SQ, SQ_CY_C, SQ_CY_B, SQ_CY_A,
    SQ_SP_SQ, SQ_SP_C, SQ_SP_B, SQ_SP_A,
    SQ_CP_SQ, SQ_CP_C, SQ_CP_B, SQ_CP_A,
    SQ_CP_GET, SQ_FX, SQ_FZ, SQ_UX, SQ_UY0, SQ_UY1, SQ_UZ,
    SQ_TX0, SQ_TX1, SQ_TY0, SQ_TY1, SQ_TY2, SQ_TZ0, SQ_TZ1, SQ_TZ2, SQ_END
  } step_e;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_op_t;

  typedef struct packed {
    logic signed [15:0] side_x;
    logic signed [15:0] side_z;
    logic signed [15:0] upv_x;
    logic signed [15:0] upv_y;
    logic signed [15:0] upv_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } res_t;

  // fraction within the quadrant, Q15, 0..32768
  function automatic logic [16:0] quad_x(input logic [15:0] a);
    logic [16:0] x0;
    x0 = {2'b00, a[13:0], 1'b0};
    return a[14] ? (QUAD_ONE - x0) : x0;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v < -52'sd32768) return 16'sh8000;
    if (v > 52'sd32767) return 16'sh7fff;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] dot_sat(input logic signed [ACC_W-1:0] sum,
                                                 input logic neg);
    logic signed [ACC_W-1:0] v;
    v = sum >>> 15;
    if (neg) v = -v;
    if (v < -52'sd2147483648) return 32'sh80000000;
    if (v > 52'sd2147483647) return 32'sh7fffffff;
    return v[31:0];
  endfunction

endpackage

// ----- src/fpv_in_if.sv -----
// Input channel: camera entity update request.
`timescale 1ns / 1ps
interface fpv_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         entity_index;
  logic signed [15:0] mouse_dx;
  logic signed [15:0] mouse_dy;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        height_scale;

  modport source (output valid, entity_index, mouse_dx, mouse_dy, pos_x, pos_y, pos_z,
                  height_scale, input ready);
  modport sink (input valid, entity_index, mouse_dx, mouse_dy, pos_x, pos_y, pos_z,
                height_scale, output ready);
endinterface

// ----- src/fpv_out_if.sv -----
// Output channel: view matrix rows and translation.
`timescale 1ns / 1ps
interface fpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] side_x;
  logic signed [15:0] side_z;
  logic signed [15:0] upv_x;
  logic signed [15:0] upv_y;
  logic signed [15:0] upv_z;
  logic signed [15:0] back_x;
  logic signed [15:0] back_y;
  logic signed [15:0] back_z;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (output valid, side_x, side_z, upv_x, upv_y, upv_z, back_x, back_y, back_z,
                  trans_x, trans_y, trans_z, input ready);
  modport sink (input valid, side_x, side_z, upv_x, upv_y, upv_z, back_x, back_y, back_z,
                trans_x, trans_y, trans_z, output ready);
endinterface

// ----- src/fpv_mac.sv -----
// Shared multiply-accumulate unit used by the view matrix sequencer.
`timescale 1ns / 1ps
module fpv_mac (
  input  logic                                clk_i,
  input  fpv_pkg::mac_op_t                    op_i,
  input  logic signed [fpv_pkg::MA_W-1:0]     a_i,
  input  logic signed [fpv_pkg::MB_W-1:0]     b_i,
  output logic signed [fpv_pkg::ACC_W-1:0]    acc_o
);
  import fpv_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_d, acc_q;

  assign prod  = ACC_W'(a_i) * ACC_W'(b_i);
  assign acc_d = op_i.clr ? prod : (acc_q + prod);

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- src/first_person_view_matrix_unit.sv -----
// Top level: first-person camera view matrix with per-entity yaw/pitch state.
//
//  channel   dir   handshake        payload
//  in_ch     in    valid/ready      entity_index, mouse_dx/dy, pos_x/y/z, height_scale
//  out_ch    out   valid/ready      side, upv, back rows (Q1.15), trans_x/y/z (Q16.16)
//  cfg       in    cfg_we_i         look_sensitivity (Q8.8)
//
// An item is accepted, then runs through 34 sequencer steps; 32 of the steps
// pass a product through the shared 18x34 multiply-accumulate unit.
// Reset clears the sequencer, output valid and the angle valid bits, and sets the
// sensitivity to 1.0. Angles live in a small memory; an entry whose valid bit is clear
// reads as zero. A finished result waits in the output register; the next item is taken
// meanwhile and only its last step stalls while that register is still full.
`timescale 1ns / 1ps
module first_person_view_matrix_unit #(
  parameter int MAX_CAMERAS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  fpv_in_if.sink      in_ch,
  fpv_out_if.source   out_ch
);
  import fpv_pkg::*;

  localparam int IW   = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int NIDX = 16;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  logic [15:0] sens_q;
  logic [MAX_CAMERAS-1:0] vld_q;
  logic [31:0] ang_mem [MAX_CAMERAS];
  logic [31:0] rd_q;

  logic [IW-1:0] idx_lut [NIDX];
  logic [IW-1:0] in_idx, idx_q;

  logic signed [15:0] dx_q, dy_q;
  logic signed [31:0] px_q, pz_q;
  logic signed [32:0] ey_q;

  logic [15:0] yaw_q, yaw_d, pitch_q, pitch_d, yaw_c, pitch_c;
  logic [15:0] old_yaw, old_pitch, pitch_new;
  logic signed [ACC_W-1:0] acc, sh8, sh15, p_sum;

  logic [16:0] x2_q, x2_d;
  logic signed [MA_W-1:0] sy_q, sy_d, cy_q, cy_d, sp_q, sp_d, cp_q, cp_d;
  logic signed [MA_W-1:0] r_pos, r_neg, m1_q, m1_d;
  logic signed [15:0] fx_q, fx_d, fy_q, fy_d, fz_q, fz_d, sx_q, sx_d, sz_q, sz_d;
  logic signed [15:0] ux_q, ux_d, uy_q, uy_d, uz_q, uz_d;
  logic signed [31:0] tx_q, tx_d, ty_q, ty_d;

  logic [15:0] ang;
  logic [16:0] x_cur;
  mac_op_t mac_op;
  logic signed [MA_W-1:0] mac_a;
  logic signed [MB_W-1:0] mac_b;

  logic in_acc, mem_we, out_free, out_load;
  res_t res_q, res_d;

  for (genvar v = 0; v < NIDX; v++) begin : g_idx
    assign idx_lut[v] = IW'(v % MAX_CAMERAS);
  end

  assign in_idx   = idx_lut[in_ch.entity_index];
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;

  assign old_yaw   = vld_q[idx_q] ? rd_q[31:16] : 16'd0;
  assign old_pitch = vld_q[idx_q] ? rd_q[15:0]  : 16'd0;
  assign yaw_c     = yaw_q + QUARTER_TURN;
  assign pitch_c   = pitch_q + QUARTER_TURN;

  assign sh8   = acc >>> 8;
  assign sh15  = acc >>> 15;
  assign r_pos = sh15[MA_W-1:0];
  assign r_neg = -r_pos;
  assign p_sum = ACC_W'($signed(old_pitch)) + sh8;
  assign pitch_new = (p_sum > PITCH_MAX) ? PITCH_MAX[15:0] :
                     (p_sum < PITCH_MIN) ? PITCH_MIN[15:0] : p_sum[15:0];

  fpv_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  always_comb begin
    case (step_q)
      SQ_SY_SQ, SQ_SY_C, SQ_SY_B, SQ_SY_A: ang = yaw_q;
      SQ_CY_SQ, SQ_CY_C, SQ_CY_B, SQ_CY_A: ang = yaw_c;
      SQ_SP_SQ, SQ_SP_C, SQ_SP_B, SQ_SP_A: ang = pitch_q;
      default:                             ang = pitch_c;
    endcase
  end

  assign x_cur = quad_x(ang);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    yaw_d    = yaw_q;
    pitch_d  = pitch_q;
    x2_d     = x2_q;
    sy_d     = sy_q;
    cy_d     = cy_q;
    sp_d     = sp_q;
    cp_d     = cp_q;
    m1_d     = m1_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    fz_d     = fz_q;
    sx_d     = sx_q;
    sz_d     = sz_q;
    ux_d     = ux_q;
    uy_d     = uy_q;
    uz_d     = uz_q;
    tx_d     = tx_q;
    ty_d     = ty_q;
    mac_op   = '{en: 1'b0, clr: 1'b1};
    mac_a    = '0;
    mac_b    = '0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    res_d    = res_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          step_d  = SQ_DYAW;
        end
      end
      ST_RUN: begin
        if (step_q != SQ_END) begin
          step_d = step_e'(step_q + 6'd1);
        end
        case (step_q)
          SQ_DYAW: begin
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(dx_q);
            mac_b  = MB_W'(sens_q);
          end
          SQ_DPITCH: begin
            yaw_d  = old_yaw + sh8[15:0];
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(dy_q);
            mac_b  = MB_W'(sens_q);
          end
          SQ_SY_SQ, SQ_CY_SQ, SQ_SP_SQ, SQ_CP_SQ: begin
            case (step_q)
              SQ_SY_SQ: begin
                pitch_d = pitch_new;
                mem_we  = 1'b1;
              end
              SQ_CY_SQ: sy_d = yaw_q[15] ? r_neg : r_pos;
              SQ_SP_SQ: cy_d = yaw_c[15] ? r_neg : r_pos;
              default:  sp_d = pitch_q[15] ? r_neg : r_pos;
            endcase
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(x_cur);
            mac_b  = MB_W'(x_cur);
          end
          SQ_SY_C, SQ_CY_C, SQ_SP_C, SQ_CP_C: begin
            x2_d   = sh15[16:0];
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(sh15);
            mac_b  = POLY_C;
          end
          SQ_SY_B, SQ_CY_B, SQ_SP_B, SQ_CP_B: begin
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(x2_q);
            mac_b  = POLY_B - MB_W'(sh15);
          end
          SQ_SY_A, SQ_CY_A, SQ_SP_A, SQ_CP_A: begin
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(x_cur);
            mac_b  = POLY_A - MB_W'(sh15);
          end
          SQ_CP_GET: begin
            cp_d = pitch_c[15] ? r_neg : r_pos;
          end
          SQ_FX: begin
            fy_d   = sat16(ACC_W'(sp_q));
            sx_d   = sat16(-ACC_W'(sy_q));
            sz_d   = sat16(ACC_W'(cy_q));
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = cy_q;
            mac_b  = MB_W'(cp_q);
          end
          SQ_FZ: begin
            fx_d   = sat16(sh15);
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = sy_q;
            mac_b  = MB_W'(cp_q);
          end
          SQ_UX: begin
            fz_d   = sat16(sh15);
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(sz_q);
            mac_b  = MB_W'(fy_q);
          end
          SQ_UY0: begin
            ux_d   = sat16(-sh15);
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(sz_q);
            mac_b  = MB_W'(fx_q);
          end
          SQ_UY1: begin
            m1_d   = sh15[MA_W-1:0];
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(sx_q);
            mac_b  = MB_W'(fz_q);
          end
          SQ_UZ: begin
            uy_d   = sat16(ACC_W'(m1_q) - sh15);
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(sx_q);
            mac_b  = MB_W'(fy_q);
          end
          SQ_TX0: begin
            uz_d   = sat16(sh15);
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(sx_q);
            mac_b  = MB_W'(px_q);
          end
          SQ_TX1: begin
            mac_op = '{en: 1'b1, clr: 1'b0};
            mac_a  = MA_W'(sz_q);
            mac_b  = MB_W'(pz_q);
          end
          SQ_TY0: begin
            tx_d   = dot_sat(acc, 1'b1);
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(ux_q);
            mac_b  = MB_W'(px_q);
          end
          SQ_TY1: begin
            mac_op = '{en: 1'b1, clr: 1'b0};
            mac_a  = MA_W'(uy_q);
            mac_b  = MB_W'(ey_q);
          end
          SQ_TY2: begin
            mac_op = '{en: 1'b1, clr: 1'b0};
            mac_a  = MA_W'(uz_q);
            mac_b  = MB_W'(pz_q);
          end
          SQ_TZ0: begin
            ty_d   = dot_sat(acc, 1'b1);
            mac_op = '{en: 1'b1, clr: 1'b1};
            mac_a  = MA_W'(fx_q);
            mac_b  = MB_W'(px_q);
          end
          SQ_TZ1: begin
            mac_op = '{en: 1'b1, clr: 1'b0};
            mac_a  = MA_W'(fy_q);
            mac_b  = MB_W'(ey_q);
          end
          SQ_TZ2: begin
            mac_op = '{en: 1'b1, clr: 1'b0};
            mac_a  = MA_W'(fz_q);
            mac_b  = MB_W'(pz_q);
          end
          SQ_END: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = ST_IDLE;
              step_d   = SQ_DYAW;
              res_d.side_x  = sx_q;
              res_d.side_z  = sz_q;
              res_d.upv_x   = ux_q;
              res_d.upv_y   = uy_q;
              res_d.upv_z   = uz_q;
              res_d.back_x  = sat16(-ACC_W'(fx_q));
              res_d.back_y  = sat16(-ACC_W'(fy_q));
              res_d.back_z  = sat16(-ACC_W'(fz_q));
              res_d.trans_x = tx_q;
              res_d.trans_y = ty_q;
              res_d.trans_z = dot_sat(acc, 1'b0);
            end
          end
          default: begin
            step_d = SQ_END;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= SQ_DYAW;
      sens_q       <= SENS_RESET;
      vld_q        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        sens_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ang_mem[idx_q] <= {yaw_q, pitch_new};
    end
    if (in_acc) begin
      rd_q  <= ang_mem[in_idx];
      idx_q <= in_idx;
      dx_q  <= in_ch.mouse_dx;
      dy_q  <= in_ch.mouse_dy;
      px_q  <= in_ch.pos_x;
      pz_q  <= in_ch.pos_z;
      ey_q  <= 33'(in_ch.pos_y) + 33'(in_ch.height_scale >> 2);
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_q   <= yaw_d;
    pitch_q <= pitch_d;
    x2_q    <= x2_d;
    sy_q    <= sy_d;
    cy_q    <= cy_d;
    sp_q    <= sp_d;
    cp_q    <= cp_d;
    m1_q    <= m1_d;
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    fz_q    <= fz_d;
    sx_q    <= sx_d;
    sz_q    <= sz_d;
    ux_q    <= ux_d;
    uy_q    <= uy_d;
    uz_q    <= uz_d;
    tx_q    <= tx_d;
    ty_q    <= ty_d;
    res_q   <= res_d;
  end

  assign out_ch.side_x  = res_q.side_x;
  assign out_ch.side_z  = res_q.side_z;
  assign out_ch.upv_x   = res_q.upv_x;
  assign out_ch.upv_y   = res_q.upv_y;
  assign out_ch.upv_z   = res_q.upv_z;
  assign out_ch.back_x  = res_q.back_x;
  assign out_ch.back_y  = res_q.back_y;
  assign out_ch.back_z  = res_q.back_z;
  assign out_ch.trans_x = res_q.trans_x;
  assign out_ch.trans_y = res_q.trans_y;
  assign out_ch.trans_z = res_q.trans_z;

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN && step_q == SQ_DYAW))
    else $error("sequencer did not start after input transfer");

  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ($signed(pitch_new) <= 16'sd16382 && $signed(pitch_new) >= -16'sd16382))
    else $error("stored pitch outside limit");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == SQ_END && !out_free)
      |=> (state_q == ST_RUN && step_q == SQ_END))
    else $error("result dropped while output register full");

endmodule
